// ===== hw/rtl/fbcu_pkg.sv =====
`timescale 1ns / 1ps

package fbcu_pkg;

   // Code geometry of the compressed stream.
   localparam int unsigned CODE_W   = 5;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEFT_W   = 4;
   localparam int unsigned LCOUNT_W = 3;
   localparam logic [CODE_W-1:0] END_CODE = 5'h1F;

   // Dictionary register file.
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned DICT3_W    = 56;

   localparam logic [CSR_IDX_W-1:0] CSR_DICT_0_TO_7   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DICT_8_TO_15  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DICT_16_TO_23 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DICT_24_TO_30 = 2'd3;

   // One compressed byte on the request channel.
   typedef struct packed {
      logic [BYTE_W-1:0] packed_byte;
      logic              stream_start;
   } req_type;

   // One decoded character on the response channel.
   typedef struct packed {
      logic [BYTE_W-1:0] out_char;
      logic              end_marker;
      logic              last_of_run;
   } rsp_type;

   // Head of the code buffer, handed from the unpacker to the output stage.
   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
      logic              last;
   } slot_type;

endpackage

// ===== hw/rtl/five_bit_code_unpack_lookup.sv =====
`timescale 1ns / 1ps
// A byte's codes go to the code buffer, then one at a time to the output register.
// Unless the output stalls: one byte per cycle for one-code bytes, one character per
// cycle out, and a two-code byte holds off the next until its last code is taken.
// Reset (synchronous): clears leftover bits, the end flag, the code buffer,
// the output valid and all dictionary registers.
module five_bit_code_unpack_lookup (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  fbcu_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output fbcu_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [fbcu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fbcu_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fbcu_pkg::*;

   slot_type slot;
   logic     take;

   // Bit unpacking and code buffer.
   fbcu_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .take      (take),
      .slot      (slot)
   );

   // Dictionary lookup and output register.
   fbcu_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .slot      (slot),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // The end of a stream is always the final character of its byte.
   a_end_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.end_marker |-> rsp_data.last_of_run)
      else $error("end marker without last_of_run");

   // The terminator carries no character.
   a_end_char_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.end_marker |-> rsp_data.out_char == 8'h00)
      else $error("end marker with nonzero character");

   // A second buffered code holds off the next byte.
   a_two_codes_stall : assert property (@(posedge clock) disable iff (reset)
      slot.valid && !slot.last |-> req_stall)
      else $error("byte accepted while two codes are buffered");

   // A buffered code reaches the output register as soon as it is free.
   a_slot_moves : assert property (@(posedge clock) disable iff (reset)
      slot.valid && !rsp_valid |=> rsp_valid)
      else $error("buffered code not moved to the output register");

endmodule

// ===== hw/rtl/fbcu_unpack.sv =====
`timescale 1ns / 1ps

module fbcu_unpack (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fbcu_pkg::req_type req_data,
   input  logic              take,
   output fbcu_pkg::slot_type slot
);
   import fbcu_pkg::*;

   // Stream state carried between bytes.
   logic [LEFT_W-1:0]   left_bits_ff, left_bits_in;
   logic [LCOUNT_W-1:0] left_count_ff, left_count_in;
   logic                ended_ff, ended_in;

   // Buffer of the codes of the last accepted byte.
   logic [1:0]          slot_cnt_ff;
   logic [CODE_W-1:0]   code0_ff, code1_ff;

   logic [LEFT_W-1:0]   eff_bits;
   logic [LCOUNT_W-1:0] eff_count;
   logic                eff_ended;
   logic [LEFT_W+BYTE_W-1:0] aligned;
   logic [CODE_W-1:0]   code0, code1;
   logic [1:0]          n_codes;
   logic                req_acc;

   function automatic logic [LEFT_W-1:0] low_mask(input logic [LCOUNT_W-1:0] n);
      logic [LEFT_W-1:0] m;
      case (n)
         3'd0:    m = 4'h0;
         3'd1:    m = 4'h1;
         3'd2:    m = 4'h3;
         3'd3:    m = 4'h7;
         default: m = 4'hF;
      endcase
      return m;
   endfunction

   // A start flag clears the stream state before the byte is used.
   always_comb begin
      eff_bits  = req_data.stream_start ? '0 : left_bits_ff;
      eff_count = req_data.stream_start ? '0 : left_count_ff;
      eff_ended = req_data.stream_start ? 1'b0 : ended_ff;
   end

   // Top-align the valid bits so the codes sit at fixed positions.
   assign aligned = (LEFT_W + BYTE_W)'({eff_bits, req_data.packed_byte}
                                       << (3'd4 - eff_count));
   assign code0   = aligned[11:7];
   assign code1   = aligned[6:2];

   // Cut the byte into codes and work out the leftover bits.
   always_comb begin
      n_codes       = 2'd0;
      left_count_in = eff_count;
      left_bits_in  = eff_bits;
      ended_in      = eff_ended;
      if (!eff_ended) begin
         if (code0 == END_CODE) begin
            n_codes       = 2'd1;
            left_count_in = '0;
            ended_in      = 1'b1;
         end else if (eff_count >= 3'd2) begin
            n_codes       = 2'd2;
            left_count_in = eff_count - 3'd2;
            if (code1 == END_CODE) begin
               left_count_in = '0;
               ended_in      = 1'b1;
            end
         end else begin
            n_codes       = 2'd1;
            left_count_in = eff_count + 3'd3;
         end
         left_bits_in = req_data.packed_byte[LEFT_W-1:0] & low_mask(left_count_in);
      end
   end

   // Take a new byte once the buffer is empty or hands over its last code.
   assign req_stall = slot.valid && !(take && slot.last);
   assign req_acc   = req_valid && !req_stall;

   assign slot.valid = (slot_cnt_ff != 2'd0);
   assign slot.code  = code0_ff;
   assign slot.last  = (slot_cnt_ff == 2'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_bits_ff  <= '0;
         left_count_ff <= '0;
         ended_ff      <= 1'b0;
         slot_cnt_ff   <= 2'd0;
      end else if (req_acc) begin
         left_bits_ff  <= left_bits_in;
         left_count_ff <= left_count_in;
         ended_ff      <= ended_in;
         slot_cnt_ff   <= n_codes;
      end else if (take) begin
         slot_cnt_ff   <= slot_cnt_ff - 2'd1;
      end
   end

   // Code payload; the second code moves up when the first is taken.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         code0_ff <= code0;
         code1_ff <= code1;
      end else if (take) begin
         code0_ff <= code1_ff;
      end
   end

endmodule

// ===== hw/rtl/fbcu_emit.sv =====
`timescale 1ns / 1ps

module fbcu_emit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fbcu_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbcu_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  fbcu_pkg::slot_type                  slot,
   output logic                                take,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output fbcu_pkg::rsp_type                   rsp_data
);
   import fbcu_pkg::*;

   logic [CSR_DATA_W-1:0] dict0_ff, dict1_ff, dict2_ff;
   logic [DICT3_W-1:0]    dict3_ff;
   logic [255:0]          dict_flat;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_data_in;

   // Dictionary registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dict0_ff <= '0;
         dict1_ff <= '0;
         dict2_ff <= '0;
         dict3_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DICT_0_TO_7:   dict0_ff <= csr_wdata;
            CSR_DICT_8_TO_15:  dict1_ff <= csr_wdata;
            CSR_DICT_16_TO_23: dict2_ff <= csr_wdata;
            CSR_DICT_24_TO_30: dict3_ff <= csr_wdata[DICT3_W-1:0];
         endcase
      end
   end

   // The terminator code lands on the zero byte at the top of the table.
   assign dict_flat = {8'h00, dict3_ff, dict2_ff, dict1_ff, dict0_ff};

   always_comb begin
      rsp_data_in.out_char    = dict_flat[{slot.code, 3'b000} +: BYTE_W];
      rsp_data_in.end_marker  = (slot.code == END_CODE);
      rsp_data_in.last_of_run = slot.last;
   end

   // The output register loads whenever it is empty or its transfer completes.
   assign take = slot.valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/char_stream_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the dictionary port, predicts the characters that
// each accepted byte must produce and compares them in order with the output.
module char_stream_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  fbcu_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  fbcu_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [fbcu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fbcu_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatch_count,
   output int                              chars_pending,
   output int                              bytes_decoded,
   output int                              chars_checked
);
   import fbcu_pkg::*;

   // Own copy of the dictionary and of the unpacking state.
   logic [CSR_DATA_W-1:0] dict_reg [4];
   logic [LEFT_W-1:0]     left_bits;
   int                    left_count;
   logic                  stream_done;
   rsp_type               expected_chars [$];
   rsp_type               want_char;

   task automatic flag_field(input string field, input logic [7:0] want_v,
                             input logic [7:0] got_v);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
   endtask

   // Unpacks one byte into 5-bit codes and queues the characters they stand for.
   task automatic decode_byte(input req_type item);
      logic [11:0]       acc;
      logic [11:0]       mask;
      logic [CODE_W-1:0] code;
      rsp_type           made [2];
      int                bits;
      int                n;
      n = 0;
      if (item.stream_start) begin
         left_bits = '0;
         left_count = 0;
         stream_done = 1'b0;
      end
      // Bytes after the terminator are dropped until a new stream starts.
      if (stream_done)
         return;
      bits = left_count + BYTE_W;
      acc = {left_bits, item.packed_byte};
      while (bits >= CODE_W) begin
         code = acc[bits-1 -: CODE_W];
         bits -= CODE_W;
         if (code == END_CODE) begin
            // The terminator ends the byte; any bits after it are thrown away.
            made[n] = {8'h00, 1'b1, 1'b0};
            n++;
            stream_done = 1'b1;
            bits = 0;
            break;
         end
         made[n] = {dict_reg[code[4:3]][code[2:0]*8 +: 8], 1'b0, 1'b0};
         n++;
      end
      mask = (12'd1 << bits) - 12'd1;
      left_count = bits;
      left_bits = acc[LEFT_W-1:0] & mask[LEFT_W-1:0];
      if (n > 0) begin
         made[n-1].last_of_run = 1'b1;
         bytes_decoded++;
      end
      for (int i = 0; i < n; i++)
         expected_chars.push_back(made[i]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++)
            dict_reg[i] = '0;
         left_bits = '0;
         left_count = 0;
         stream_done = 1'b0;
         expected_chars.delete();
      end else begin
         // Dictionary writes; the last register keeps only its low 56 bits.
         if (csr_we) begin
            case (csr_index)
               CSR_DICT_24_TO_30: begin
                  dict_reg[3] = csr_wdata & {{(CSR_DATA_W-DICT3_W){1'b0}}, {DICT3_W{1'b1}}};
               end
               default: begin
                  dict_reg[csr_index] = csr_wdata;
               end
            endcase
         end
         // Compare each output transfer with the oldest expected character.
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected character, expected none, actual %h", $time,
                        rsp_data);
            end else begin
               want_char = expected_chars.pop_front();
               chars_checked++;
               if (rsp_data.out_char !== want_char.out_char)
                  flag_field("out_char", want_char.out_char, rsp_data.out_char);
               if (rsp_data.end_marker !== want_char.end_marker)
                  flag_field("end_marker", want_char.end_marker, rsp_data.end_marker);
               if (rsp_data.last_of_run !== want_char.last_of_run)
                  flag_field("last_of_run", want_char.last_of_run, rsp_data.last_of_run);
            end
         end
         if (req_valid && !req_stall)
            decode_byte(req_data);
      end
      chars_pending = expected_chars.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import fbcu_pkg::*;

   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 6;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatch_count;
   int chars_pending;
   int bytes_decoded;
   int chars_checked;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_asked;
   int hold_served;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   five_bit_code_unpack_lookup DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   char_stream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending),
      .bytes_decoded  (bytes_decoded),
      .chars_checked  (chars_checked)
   );

   // Hard stop in case the block hangs.
   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Output side: random stalls, or a long hold-off when the stimulus asks for one.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served++;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Offers one byte and returns at the edge of its transfer.
   task automatic push_byte(input logic [7:0] b, input logic s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {b, s};
      do @(posedge clock); while (req_stall);
   endtask

   // Stops offering and waits until every predicted character has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_dictionary(input logic [63:0] d0, input logic [63:0] d1,
                                  input logic [63:0] d2, input logic [63:0] d3);
      csr_we <= 1'b1;
      csr_index <= CSR_DICT_0_TO_7;
      csr_wdata <= d0;
      @(posedge clock);
      csr_index <= CSR_DICT_8_TO_15;
      csr_wdata <= d1;
      @(posedge clock);
      csr_index <= CSR_DICT_16_TO_23;
      csr_wdata <= d2;
      @(posedge clock);
      csr_index <= CSR_DICT_24_TO_30;
      csr_wdata <= d3;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Packs random codes 0 to 30, optionally followed by the terminator, MSB first.
   task automatic send_stream(input int n_codes, input bit terminate, input int trailing);
      logic [15:0]       bitbuf;
      logic [CODE_W-1:0] code;
      logic [7:0]        pad;
      int                nbits;
      bit                first;
      bitbuf = '0;
      nbits = 0;
      first = 1'b1;
      for (int i = 0; i <= n_codes; i++) begin
         if (i == n_codes) begin
            if (!terminate)
               break;
            code = END_CODE;
         end else begin
            code = CODE_W'($urandom_range(30));
         end
         bitbuf = {bitbuf[10:0], code};
         nbits += CODE_W;
         if (nbits >= 8) begin
            push_byte(8'(bitbuf >> (nbits - 8)), first);
            first = 1'b0;
            nbits -= 8;
         end
      end
      // Fill the last byte with random bits.
      if (nbits > 0) begin
         pad = 8'($urandom_range(255)) >> nbits;
         push_byte(8'(bitbuf << (8 - nbits)) | pad, first);
      end
      repeat (trailing) push_byte(8'($urandom_range(255)), 1'b0);
   endtask

   // Mostly well-formed streams, some cut short, some raw noise.
   task automatic run_random(input int goal);
      int pick;
      while (bytes_decoded < goal) begin
         pick = $urandom_range(99);
         if (pick < 75)
            send_stream($urandom_range(20, 1), 1'b1,
                        ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0);
         else if (pick < 87)
            send_stream($urandom_range(12, 1), 1'b0, 0);
         else
            repeat ($urandom_range(6, 1))
               push_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
      end
   endtask

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 31;
      recv_idle_pct = 82;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Distinct character per code; the top byte of the last register must be dropped.
      load_dictionary(64'h4746454443424140, 64'h4F4E4D4C4B4A4948,
                      64'h5756555453525150, 64'hFF5E5D5C5B5A5958);

      // Leftover counts of all sizes, codes 0 and 30, and one- and two-code bytes.
      push_byte(8'h00, 1'b1);
      push_byte(8'h42, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h7B, 1'b0);
      push_byte(8'h3E, 1'b0);
      // Terminator alone in a byte, then bytes that must be ignored.
      push_byte(8'hF8, 1'b0);
      push_byte(8'hAA, 1'b0);
      push_byte(8'h55, 1'b0);
      // Terminator as the first of two codes drops the second.
      push_byte(8'h07, 1'b1);
      push_byte(8'hC0, 1'b0);
      push_byte(8'hFF, 1'b0);
      // Terminator on a start byte, then terminator as the second code.
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b1);
      push_byte(8'h3E, 1'b0);
      // A restart in the middle of a stream clears the leftover bits.
      push_byte(8'h0F, 1'b1);
      push_byte(8'h80, 1'b1);
      push_byte(8'h21, 1'b0);
      push_byte(8'hE7, 1'b0);
      push_byte(8'hFC, 1'b0);
      push_byte(8'h00, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      wait_drained();

      // Dictionary at its extremes.
      load_dictionary('1, '1, '1, '1);
      run_random(150);
      wait_drained();
      load_dictionary('0, '0, '0, '0);
      run_random(250);
      wait_drained();

      // Random dictionary, with one long output hold-off that backs up the input.
      load_dictionary({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
      run_random(350);
      hold_asked++;
      run_random(600);
      wait_drained();

      send_idle_pct = 82;
      recv_idle_pct = 31;
      load_dictionary({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
      run_random(1180);
      wait_drained();

      // Full rate both ways, with one pause of the input until the output is empty.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_dictionary({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
      run_random(1450);
      wait_drained();
      run_random(1640);
      wait_drained();

      $display("Decoded %0d bytes into %0d checked characters over six dictionaries,",
               bytes_decoded, chars_checked);
      $display("with end-of-stream cases, restarts, a long output hold-off and three idle mixes.");
      if (mismatch_count == 0 && chars_pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
